>>> src/biquad_dc_block_highpass_core_assert.svh
// Assertion macros shared by the biquad DC-block RTL.
`ifndef BIQUAD_DC_BLOCK_HIGHPASS_CORE_ASSERT_SVH
`define BIQUAD_DC_BLOCK_HIGHPASS_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define BQDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define BQDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> src/bqdc_pkg.sv
// Shared types, constants and helpers for the biquad DC-block filter.
`default_nettype none

package bqdc_pkg;

    // Coefficient and configuration port geometry
    localparam int COEF_W = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // State and product formats: 30 fraction bits, 60-bit states
    localparam int STATE_FRAC = 30;
    localparam int ST_W       = 60;
    localparam int MAG_W      = 62;
    localparam int ACC_W      = 64;
    localparam int OUT_W      = 25;

    // Product magnitude cap (2^61)
    localparam logic [MAG_W-1:0] PROD_CAP = MAG_W'(1) << 61;

    // Saturation bounds of a state word, at accumulator width
    localparam logic signed [ACC_W-1:0] ST_MAX_A = 64'sd576460752303423487;
    localparam logic signed [ACC_W-1:0] ST_MIN_A = -64'sd576460752303423488;

    // Register indexes
    localparam logic [2:0] REG_B0 = 3'd0;
    localparam logic [2:0] REG_B1 = 3'd1;
    localparam logic [2:0] REG_B2 = 3'd2;
    localparam logic [2:0] REG_A1 = 3'd3;
    localparam logic [2:0] REG_A2 = 3'd4;

    // Reset coefficients: 0.1 Hz Butterworth high-pass at 125 Sa/s
    localparam logic signed [COEF_W-1:0] B0_RST = 32'sd1069932183;
    localparam logic signed [COEF_W-1:0] B1_RST = -32'sd2139864366;
    localparam logic signed [COEF_W-1:0] B2_RST = 32'sd1069932183;
    localparam logic signed [COEF_W-1:0] A1_RST = -32'sd2139850851;
    localparam logic signed [COEF_W-1:0] A2_RST = 32'sd1066136060;

    typedef struct packed {
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
    } t_coefs;

    // Request to the shared multiplier: sign-magnitude operand, raw coefficient
    typedef struct packed {
        logic              start;
        logic              neg_a;
        logic [MAG_W-1:0]  mag_a;
        logic [COEF_W-1:0] coef;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] prod;
    } t_mul_rsp;

    // Clamp an accumulator value to the state range
    function automatic logic signed [ST_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic signed [ST_W-1:0] r;
        if (v > ST_MAX_A) begin
            r = ST_MAX_A[ST_W-1:0];
        end else if (v < ST_MIN_A) begin
            r = ST_MIN_A[ST_W-1:0];
        end else begin
            r = v[ST_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/biquad_dc_block_highpass_core.sv
// Top level of the biquad DC-block high-pass filter core.
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_sample and i_leads_off. A beat is
//   taken when valid is high and stall is low; stall is high while a sample is in work.
//   Output channel: o_out_valid / i_out_stall with o_filtered, held in an output
//   register so the next sample can be taken while a result waits.
//   Coefficients b0, b1, b2, a1, a2 (signed Q2.30) sit on the APB port at byte
//   addresses 0, 4, 8, 12, 16; write them only while the core is idle.
// Sequence:
//   A filtered sample runs, from acceptance to o_out_valid, as five products on
//   the one shared 31x32 multiplier (issue and low half, high half, round and
//   cap, sign, accumulate), then the output load.
//   The input reopens after the load; no new sample is taken before then.
//   A leads-off beat bypasses the multiplier: zero output at the load, state frozen.
// Reset:
//   Synchronous active-low reset clears both delay states to zero, loads the
//   default coefficients and empties the output register.
// Back-pressure:
//   While i_out_stall holds a result, the core finishes the next sample and then
//   waits with it until the output register frees up.
`default_nettype none
`include "biquad_dc_block_highpass_core_assert.svh"

module biquad_dc_block_highpass_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_leads_off,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [bqdc_pkg::OUT_W-1:0]  o_filtered,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bqdc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bqdc_pkg::DATA_W-1:0]   pwdata,
    output logic      [bqdc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int ST_W  = bqdc_pkg::ST_W;
    localparam int ACC_W = bqdc_pkg::ACC_W;
    localparam int MAG_W = bqdc_pkg::MAG_W;
    localparam int OUT_W = bqdc_pkg::OUT_W;
    localparam int RQ_W  = ST_W - bqdc_pkg::STATE_FRAC + 1;
    localparam logic [RQ_W-1:0] OUT_POS_LIM = RQ_W'(1) << (OUT_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        STEP_B0,
        STEP_B1,
        STEP_A1,
        STEP_B2,
        STEP_A2
    } t_step;

    t_state                   r_state;
    t_step                    r_step;
    logic                     r_xneg;
    logic [MAG_W-1:0]         r_xmag;
    logic                     r_yneg;
    logic [ST_W-1:0]          r_ymag;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ST_W-1:0]   r_s1;
    logic signed [ST_W-1:0]   r_s2;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_filtered;

    bqdc_pkg::t_coefs         coefs;
    bqdc_pkg::t_mul_req       mul_req;
    bqdc_pkg::t_mul_rsp       mul_rsp;

    logic                     in_acc;
    logic                     out_free;
    logic [SAMPLE_BITS-1:0]   n_xabs;
    logic signed [ST_W-1:0]   n_y;
    logic [ST_W-1:0]          n_ymag;
    logic [RQ_W-1:0]          n_rq;
    logic signed [OUT_W-1:0]  n_filt;

    // Coefficient registers
    bqdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    // Shared multiplier
    bqdc_mul #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    // Sample magnitude, scaled to 30 fraction bits at load
    assign n_xabs = i_sample[SAMPLE_BITS-1] ?
                    (SAMPLE_BITS'(0) - $unsigned(i_sample)) : $unsigned(i_sample);

    // Operand select per step
    always_comb begin
        mul_req.start = (r_state == S_ISSUE);
        case (r_step)
            STEP_B0: begin
                mul_req.neg_a = r_xneg;
                mul_req.mag_a = r_xmag;
                mul_req.coef  = coefs.b0;
            end
            STEP_B1: begin
                mul_req.neg_a = r_xneg;
                mul_req.mag_a = r_xmag;
                mul_req.coef  = coefs.b1;
            end
            STEP_A1: begin
                mul_req.neg_a = r_yneg;
                mul_req.mag_a = MAG_W'(r_ymag);
                mul_req.coef  = coefs.a1;
            end
            STEP_B2: begin
                mul_req.neg_a = r_xneg;
                mul_req.mag_a = r_xmag;
                mul_req.coef  = coefs.b2;
            end
            STEP_A2: begin
                mul_req.neg_a = r_yneg;
                mul_req.mag_a = MAG_W'(r_ymag);
                mul_req.coef  = coefs.a2;
            end
            default: begin
                mul_req.neg_a = 1'b0;
                mul_req.mag_a = '0;
                mul_req.coef  = '0;
            end
        endcase
    end

    // Filter output y = sat(b0*x + s1), kept as sign and magnitude
    assign n_y    = bqdc_pkg::sat_state(mul_rsp.prod + ACC_W'(r_s1));
    assign n_ymag = n_y[ST_W-1] ? (ST_W'(0) - $unsigned(n_y)) : $unsigned(n_y);

    // Round half away from zero to an integer and clamp to the output range
    assign n_rq = RQ_W'((ST_W'(r_ymag) + (ST_W'(1) << (bqdc_pkg::STATE_FRAC - 1)))
                        >> bqdc_pkg::STATE_FRAC);
    always_comb begin
        if (r_yneg) begin
            if (n_rq > OUT_POS_LIM) begin
                n_filt = -$signed(OUT_POS_LIM[OUT_W-1:0]);
            end else begin
                n_filt = $signed(OUT_W'(0) - n_rq[OUT_W-1:0]);
            end
        end else begin
            if (n_rq >= OUT_POS_LIM) begin
                n_filt = $signed(OUT_POS_LIM[OUT_W-1:0] - OUT_W'(1));
            end else begin
                n_filt = $signed(n_rq[OUT_W-1:0]);
            end
        end
    end

    // Sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_B0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output register: load a finished result, else drop an accepted beat
            if ((r_state == S_OUT) && out_free) begin
                r_filtered  <= n_filt;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_xneg <= i_sample[SAMPLE_BITS-1];
                        r_xmag <= MAG_W'(n_xabs) << bqdc_pkg::STATE_FRAC;
                        r_step <= STEP_B0;
                        if (i_leads_off) begin
                            // Zero output, state untouched
                            r_yneg  <= 1'b0;
                            r_ymag  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (mul_rsp.done) begin
                        r_state <= S_ISSUE;
                        case (r_step)
                            STEP_B0: begin
                                r_yneg <= n_y[ST_W-1];
                                r_ymag <= n_ymag;
                                r_step <= STEP_B1;
                            end
                            STEP_B1: begin
                                r_acc  <= mul_rsp.prod;
                                r_step <= STEP_A1;
                            end
                            STEP_A1: begin
                                r_s1   <= bqdc_pkg::sat_state(r_acc - mul_rsp.prod
                                                              + ACC_W'(r_s2));
                                r_step <= STEP_B2;
                            end
                            STEP_B2: begin
                                r_acc  <= mul_rsp.prod;
                                r_step <= STEP_A2;
                            end
                            STEP_A2: begin
                                r_s2    <= bqdc_pkg::sat_state(r_acc - mul_rsp.prod);
                                r_step  <= STEP_B0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_step  <= STEP_B0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BQDC_ASSERT(a_leads_off_freeze, i_clk, i_rst_n, (in_acc && i_leads_off) |=> ($stable(r_s1) && $stable(r_s2)), "state changed on leads-off sample")
    `BQDC_ASSERT(a_done_while_waiting, i_clk, i_rst_n, mul_rsp.done |-> (r_state == S_WAIT), "product arrived outside wait")
    `BQDC_ASSERT(a_out_hold, i_clk, i_rst_n, ((r_state == S_OUT) && r_out_valid && i_out_stall) |=> ((r_state == S_OUT) && r_out_valid), "pending result overwritten")
    `BQDC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> ((r_state == S_IDLE) && !r_out_valid), "reset did not idle the core")

endmodule

`default_nettype wire

>>> src/bqdc_regs.sv
// APB coefficient register file for the biquad DC-block filter.
`default_nettype none

module bqdc_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bqdc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bqdc_pkg::DATA_W-1:0] pwdata,
    output logic      [bqdc_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output bqdc_pkg::t_coefs                 o_coefs
);

    bqdc_pkg::t_coefs r_coefs;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[bqdc_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_coefs = r_coefs;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= bqdc_pkg::B0_RST;
            r_coefs.b1 <= bqdc_pkg::B1_RST;
            r_coefs.b2 <= bqdc_pkg::B2_RST;
            r_coefs.a1 <= bqdc_pkg::A1_RST;
            r_coefs.a2 <= bqdc_pkg::A2_RST;
        end else if (wr_en) begin
            case (reg_idx)
                bqdc_pkg::REG_B0: r_coefs.b0 <= pwdata;
                bqdc_pkg::REG_B1: r_coefs.b1 <= pwdata;
                bqdc_pkg::REG_B2: r_coefs.b2 <= pwdata;
                bqdc_pkg::REG_A1: r_coefs.a1 <= pwdata;
                bqdc_pkg::REG_A2: r_coefs.a2 <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            bqdc_pkg::REG_B0: prdata = r_coefs.b0;
            bqdc_pkg::REG_B1: prdata = r_coefs.b1;
            bqdc_pkg::REG_B2: prdata = r_coefs.b2;
            bqdc_pkg::REG_A1: prdata = r_coefs.a1;
            bqdc_pkg::REG_A2: prdata = r_coefs.a2;
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/bqdc_mul.sv
// Shared multi-cycle coefficient multiplier with rounding and magnitude cap.
`default_nettype none
`include "biquad_dc_block_highpass_core_assert.svh"

module bqdc_mul #(
    parameter int COEF_FRAC_BITS = 30
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bqdc_pkg::t_mul_req i_req,
    output bqdc_pkg::t_mul_rsp      o_rsp
);

    localparam int HALF_W = bqdc_pkg::MAG_W / 2;
    localparam int PP_W   = HALF_W + bqdc_pkg::COEF_W;
    localparam int FULL_W = PP_W + HALF_W + 1;
    localparam logic [FULL_W-1:0] RND_ONE = FULL_W'(1) << (COEF_FRAC_BITS - 1);

    typedef enum logic [1:0] {
        M_IDLE,
        M_HI,
        M_RND,
        M_NEG
    } t_mstate;

    t_mstate                          r_state;
    logic                             r_done;
    logic                             r_neg;
    logic [HALF_W-1:0]                r_ahi;
    logic [bqdc_pkg::COEF_W-1:0]      r_cm;
    logic [PP_W-1:0]                  r_plo;
    logic [PP_W-1:0]                  r_phi;
    logic [bqdc_pkg::MAG_W-1:0]       r_mag;
    logic signed [bqdc_pkg::ACC_W-1:0] r_prod;

    logic [bqdc_pkg::COEF_W-1:0]      n_cm;
    logic [FULL_W-1:0]                n_full;
    logic [FULL_W-1:0]                n_shift;
    logic [bqdc_pkg::ACC_W-1:0]       n_pm;

    // Coefficient magnitude (two's complement raw word)
    assign n_cm = i_req.coef[bqdc_pkg::COEF_W-1] ?
                  (bqdc_pkg::COEF_W'(0) - i_req.coef) : i_req.coef;

    // Recombine partial products, round half up on the magnitude, rescale
    assign n_full  = (FULL_W'(r_phi) << HALF_W) + FULL_W'(r_plo) + RND_ONE;
    assign n_shift = n_full >> COEF_FRAC_BITS;
    assign n_pm    = bqdc_pkg::ACC_W'(r_mag);

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

    // Sequencer: low half, high half, round and cap, apply sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_plo   <= PP_W'(i_req.mag_a[HALF_W-1:0]) * PP_W'(n_cm);
                        r_ahi   <= i_req.mag_a[bqdc_pkg::MAG_W-1:HALF_W];
                        r_cm    <= n_cm;
                        r_neg   <= i_req.neg_a ^ i_req.coef[bqdc_pkg::COEF_W-1];
                        r_state <= M_HI;
                    end
                end
                M_HI: begin
                    r_phi   <= PP_W'(r_ahi) * PP_W'(r_cm);
                    r_state <= M_RND;
                end
                M_RND: begin
                    if (n_shift > FULL_W'(bqdc_pkg::PROD_CAP)) begin
                        r_mag <= bqdc_pkg::PROD_CAP;
                    end else begin
                        r_mag <= n_shift[bqdc_pkg::MAG_W-1:0];
                    end
                    r_state <= M_NEG;
                end
                M_NEG: begin
                    r_prod  <= r_neg ? (bqdc_pkg::ACC_W'(0) - n_pm) : n_pm;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    `BQDC_ASSERT(a_start_when_idle, i_clk, i_rst_n, i_req.start |-> (r_state == M_IDLE), "multiplier started while busy")
    `BQDC_ASSERT(a_done_after_neg, i_clk, i_rst_n, r_done |-> ($past(r_state) == M_NEG), "product done out of sequence")
    `BQDC_ASSERT(a_prod_capped, i_clk, i_rst_n, r_done |-> ((r_prod <= $signed(n_pm | bqdc_pkg::ACC_W'(bqdc_pkg::PROD_CAP))) && (r_prod >= -$signed(bqdc_pkg::ACC_W'(bqdc_pkg::PROD_CAP)))), "product beyond cap")

endmodule

`default_nettype wire

>>> dv/biquad_dc_block_highpass_core_tb.sv
// Self-checking testbench for the biquad DC-block high-pass core: random-gap stimulus, scoreboard.
`timescale 1ns / 1ps

module biquad_dc_block_highpass_core_tb;

    localparam int  COEF_FRAC     = 30;
    localparam int  Y_FRAC        = 30;
    localparam int  SAMPLE_MAX    = 8388607;
    localparam int  SAMPLE_MIN    = -8388608;
    localparam int  SETTLE_CYCLES = 64;
    localparam int  RUN_LIMIT     = 1000000;
    localparam int  PHASE_BEATS   = 110;

    localparam logic [63:0]        MAG_CAP  = 64'd1 << 61;
    localparam logic signed [63:0] STATE_HI = 64'sd576460752303423487;
    localparam logic signed [63:0] STATE_LO = -64'sd576460752303423488;
    localparam logic signed [63:0] OUT_HI   = 64'sd16777215;
    localparam logic signed [63:0] OUT_LO   = -64'sd16777216;

    typedef enum int {
        PROF_DEFAULT, PROF_MAX, PROF_MIN, PROF_RANDOM, PROF_MILD, PROF_MIXED
    } t_coef_profile;

    typedef struct packed {
        logic signed [23:0] sample;
        logic               leads_off;
        logic               drain_first;  // hold until every pending result is back
    } t_beat;

    // DUT connections
    logic                               i_clk;
    logic                               i_rst_n    = 1'b0;
    logic                               in_valid   = 1'b0;
    logic signed [23:0]                 sample_drv = '0;
    logic                               leads_drv  = 1'b0;
    logic                               out_stall  = 1'b0;
    logic                               psel       = 1'b0;
    logic                               penable    = 1'b0;
    logic                               pwrite     = 1'b0;
    logic [bqdc_pkg::ADDR_W-1:0]        paddr      = '0;
    logic [bqdc_pkg::DATA_W-1:0]        pwdata     = '0;
    wire logic                          o_in_stall;
    wire logic                          o_out_valid;
    wire logic signed [24:0]            o_filtered;
    wire logic [bqdc_pkg::DATA_W-1:0]   prdata;
    wire logic                          pready;

    // Filter shadow: coefficients and delay states
    logic [31:0]        coef_shadow [5];
    logic signed [63:0] delay_one_q;
    logic signed [63:0] delay_two_q;

    // Driver and scoreboard bookkeeping
    t_beat              pending_beats [$];
    logic signed [24:0] expected_filtered [$];
    t_beat              cur_beat;
    int                 in_gap        = 0;
    logic               in_quiet      = 1'b0;
    int                 stall_left    = 0;
    logic               out_quiet     = 1'b0;
    int                 beats_accepted = 0;
    int                 results_seen  = 0;
    int                 fail_count    = 0;
    int                 cycle_count   = 0;

    biquad_dc_block_highpass_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (sample_drv),
        .i_leads_off (leads_drv),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_filtered  (o_filtered),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] reset_coef(input int k);
        case (k)
            bqdc_pkg::REG_B0: return bqdc_pkg::B0_RST;
            bqdc_pkg::REG_B1: return bqdc_pkg::B1_RST;
            bqdc_pkg::REG_B2: return bqdc_pkg::B2_RST;
            bqdc_pkg::REG_A1: return bqdc_pkg::A1_RST;
            default:          return bqdc_pkg::A2_RST;
        endcase
    endfunction

    // v * coef / 2^frac, sign-magnitude, rounded half away from zero, magnitude capped
    function automatic logic signed [63:0] scale_by_coef(input logic signed [63:0] v,
                                                          input logic [31:0] c);
        logic [63:0]  vm;
        logic [63:0]  cm;
        logic [127:0] prod;
        logic [63:0]  m;
        logic         neg;
        vm   = v[63] ? 64'(-v) : 64'(v);
        cm   = c[31] ? 64'h1_0000_0000 - {32'd0, c} : {32'd0, c};
        prod = {64'd0, vm} * {64'd0, cm};
        prod = (prod + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
        m    = (prod > {64'd0, MAG_CAP}) ? MAG_CAP : prod[63:0];
        neg  = v[63] ^ c[31];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clamp_state(input logic signed [63:0] v);
        if (v > STATE_HI) return STATE_HI;
        if (v < STATE_LO) return STATE_LO;
        return v;
    endfunction

    // One TDF-II step; advances the shadow states unless leads are off
    function automatic logic signed [24:0] predict_filtered(input t_beat b);
        logic signed [63:0] xf;
        logic signed [63:0] y;
        logic signed [63:0] n1;
        logic signed [63:0] n2;
        logic [63:0]        mag;
        logic signed [63:0] o;
        if (b.leads_off) return '0;
        xf = {{40{b.sample[23]}}, b.sample};
        xf = xf <<< Y_FRAC;
        y  = clamp_state(scale_by_coef(xf, coef_shadow[bqdc_pkg::REG_B0]) + delay_one_q);
        n1 = clamp_state(scale_by_coef(xf, coef_shadow[bqdc_pkg::REG_B1])
                         - scale_by_coef(y, coef_shadow[bqdc_pkg::REG_A1]) + delay_two_q);
        n2 = clamp_state(scale_by_coef(xf, coef_shadow[bqdc_pkg::REG_B2])
                         - scale_by_coef(y, coef_shadow[bqdc_pkg::REG_A2]));
        delay_one_q = n1;
        delay_two_q = n2;
        mag = y[63] ? 64'(-y) : 64'(y);
        mag = (mag + (64'd1 << (Y_FRAC - 1))) >> Y_FRAC;
        o   = y[63] ? -$signed(mag) : $signed(mag);
        if (o > OUT_HI) o = OUT_HI;
        if (o < OUT_LO) o = OUT_LO;
        return o[24:0];
    endfunction

    // Mostly short gaps, some medium, a few long; none in quiet stretches
    function automatic int draw_gap(input logic quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Input driver: presents queued beats, holds a beat stable while stalled
    always @(posedge i_clk) begin : drive_samples
        logic took;
        took = 1'b0;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            took = in_valid && !o_in_stall;
            if (took) begin
                expected_filtered.push_back(predict_filtered(cur_beat));
                beats_accepted <= beats_accepted + 1;
                if ($urandom_range(0, 63) == 0) in_quiet = !in_quiet;
            end
            if (!(in_valid && !took)) begin
                if (in_gap != 0) begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() != 0 &&
                             !(pending_beats[0].drain_first &&
                               (took || beats_accepted != results_seen))) begin
                    cur_beat = pending_beats.pop_front();
                    in_valid   <= 1'b1;
                    sample_drv <= cur_beat.sample;
                    leads_drv  <= cur_beat.leads_off;
                    in_gap = draw_gap(in_quiet);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted beat against the oldest prediction
    always @(posedge i_clk) begin : check_results
        logic signed [24:0] want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_seen <= results_seen + 1;
                if (expected_filtered.size() == 0) begin
                    $error("unexpected result: filtered %0d", o_filtered);
                    fail_count++;
                end else begin
                    want = expected_filtered.pop_front();
                    if (o_filtered !== want) begin
                        $error("filtered mismatch: expected %0d, actual %0d", want, o_filtered);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 63) == 0) out_quiet = !out_quiet;
            end
            if (stall_left == 0 && !out_quiet && $urandom_range(0, 3) == 0)
                stall_left = draw_gap(1'b0);
            out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left = stall_left - 1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // APB write: setup then access phase; shadow follows at the write edge
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx <= bqdc_pkg::REG_A2) coef_shadow[idx] = val;
    endtask

    task automatic load_profile(input t_coef_profile prof);
        logic [31:0] val;
        int k;
        for (k = 0; k < 5; k++) begin
            case (prof)
                PROF_MAX:    val = 32'h7FFF_FFFF;
                PROF_MIN:    val = 32'h8000_0000;
                PROF_RANDOM: val = $urandom;
                PROF_MILD:   val = 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
                PROF_MIXED: begin
                    case ($urandom_range(0, 4))
                        0:       val = 32'h0;
                        1:       val = 32'h7FFF_FFFF;
                        2:       val = 32'h8000_0000;
                        3:       val = 32'h4000_0000;  // unity gain
                        default: val = $urandom;
                    endcase
                end
                default:     val = reset_coef(k);
            endcase
            apb_write(3'(k), val);
        end
    endtask

    // Writes to decoded-but-unused addresses must leave the coefficients alone
    task automatic poke_spare_regs();
        int k;
        for (k = bqdc_pkg::REG_A2 + 1; k < 8; k++) apb_write(3'(k), $urandom);
    endtask

    task automatic add_beat(input int value, input logic lo, input logic drain);
        t_beat b;
        b.sample      = 24'(value);
        b.leads_off   = lo;
        b.drain_first = drain;
        pending_beats.push_back(b);
    endtask

    // Block is idle once the queue is drained, valid is low and all results are in
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || in_valid || expected_filtered.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random phase: mostly ECG-like wander with spikes, plus raw noise and edge patterns
    task automatic queue_random_phase(input int n);
        int   left;
        int   seg_len;
        int   kind;
        int   level;
        int   hold_val;
        int   k;
        logic lo;
        left  = n;
        level = 0;
        while (left > 0) begin
            kind    = $urandom_range(0, 9);
            seg_len = $urandom_range(8, 40);
            if (seg_len > left) seg_len = left;
            if ($urandom_range(0, 3) == 0)
                level = int'($urandom_range(0, 8000000)) - 4000000;
            case ($urandom_range(0, 2))
                0:       hold_val = SAMPLE_MAX;
                1:       hold_val = SAMPLE_MIN;
                default: hold_val = int'($urandom_range(0, 16777215)) - 8388608;
            endcase
            for (k = 0; k < seg_len; k++) begin
                lo = ($urandom_range(0, 99) < 3);
                case (kind)
                    5, 6: level = int'($urandom_range(0, 16777215)) - 8388608;
                    7:    level = hold_val;
                    8:    level = (k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
                    9: begin
                        level = int'($urandom_range(0, 16777215)) - 8388608;
                        lo    = ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        level = level + int'($urandom_range(0, 4000)) - 2000;
                        if ($urandom_range(0, 29) == 0)
                            level = level + int'($urandom_range(0, 1000000)) - 500000;
                    end
                endcase
                if (level > SAMPLE_MAX) level = SAMPLE_MAX;
                if (level < SAMPLE_MIN) level = SAMPLE_MIN;
                add_beat(level, lo, $urandom_range(0, 99) == 0);
            end
            left = left - seg_len;
        end
    endtask

    initial begin : stimulus
        t_coef_profile plan [8];
        int k;
        for (k = 0; k < 5; k++) coef_shadow[k] = reset_coef(k);
        delay_one_q = '0;
        delay_two_q = '0;
        plan = '{PROF_DEFAULT, PROF_MIN, PROF_RANDOM, PROF_MILD,
                 PROF_MIXED, PROF_RANDOM, PROF_MAX, PROF_DEFAULT};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: sample extremes, steps, leads-off with live state
        add_beat(0, 1'b0, 1'b0);
        for (k = 0; k < 3; k++) add_beat(SAMPLE_MAX, 1'b0, 1'b0);
        for (k = 0; k < 3; k++) add_beat(SAMPLE_MIN, 1'b0, 1'b0);
        add_beat(0, 1'b0, 1'b0);
        add_beat(1, 1'b0, 1'b0);
        add_beat(-1, 1'b0, 1'b0);
        add_beat(SAMPLE_MAX, 1'b1, 1'b0);
        add_beat(SAMPLE_MIN, 1'b1, 1'b1);
        add_beat(0, 1'b1, 1'b0);
        add_beat(12345, 1'b0, 1'b0);
        add_beat(-12345, 1'b0, 1'b0);
        for (k = 0; k < 4; k++) add_beat((k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0, 1'b0);
        wait_idle();

        // Directed: saturation with extreme coefficients, spare addresses ignored
        load_profile(PROF_MAX);
        poke_spare_regs();
        for (k = 0; k < 3; k++) add_beat(SAMPLE_MAX, 1'b0, 1'b0);
        for (k = 0; k < 2; k++) add_beat(SAMPLE_MIN, 1'b0, 1'b0);
        add_beat(SAMPLE_MAX, 1'b1, 1'b0);
        wait_idle();

        // Random phases, one coefficient setting each
        for (k = 0; k < 8; k++) begin
            load_profile(plan[k]);
            if (k == 0) poke_spare_regs();
            queue_random_phase(PHASE_BEATS);
            wait_idle();
        end

        if (fail_count == 0 && expected_filtered.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/bqdc_pkg.sv
src/bqdc_regs.sv
src/bqdc_mul.sv
src/biquad_dc_block_highpass_core.sv
dv/biquad_dc_block_highpass_core_tb.sv
